// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the block check checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// types, codes and crc tables for the packet block check
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_CHECK_TYPE = 1'b0;
    localparam logic REG_PARITY_ON  = 1'b1;

    // check type codes; zero falls back to the six-bit checksum
    localparam logic [1:0] CHK_SUM6  = 2'd1;
    localparam logic [1:0] CHK_SUM12 = 2'd2;
    localparam logic [1:0] CHK_CRC16 = 2'd3;

    localparam logic [1:0] CHECK_TYPE_RESET = CHK_SUM6;

    // reflected ccitt nibble tables, high and low nibble of the xored byte
    localparam logic [15:0] CRC_TAB_HI [16] = '{
        16'h0000, 16'h1081, 16'h2102, 16'h3183, 16'h4204, 16'h5285, 16'h6306, 16'h7387,
        16'h8408, 16'h9489, 16'hA50A, 16'hB58B, 16'hC60C, 16'hD68D, 16'hE70E, 16'hF78F
    };

    localparam logic [15:0] CRC_TAB_LO [16] = '{
        16'h0000, 16'h1189, 16'h2312, 16'h329B, 16'h4624, 16'h57AD, 16'h6536, 16'h74BF,
        16'h8C48, 16'h9DC1, 16'hAF5A, 16'hBED3, 16'hCA6C, 16'hDBE5, 16'hE97E, 16'hF8F7
    };

    // one byte moving from the input register into the check logic
    typedef struct packed {
        logic step;
        logic last;
    } pbc_step_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = b ^ crc[7:0];
        return {8'h00, crc[15:8]} ^ CRC_TAB_HI[c[7:4]] ^ CRC_TAB_LO[c[3:0]];
    endfunction

endpackage

// ===== rtl/pbc_core.sv =====
// ----------------------------------------------------------------------------
// pbc_core
// running byte sum and crc, with the check picked on the last byte
// ----------------------------------------------------------------------------
module pbc_core
    import pbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pbc_step_t   step,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  check_type,
    input  logic        parity_on,
    output logic [15:0] check_value
);

    logic [11:0] sum_reg;
    logic [11:0] sum_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  b;
    logic [5:0]  sum6;

    assign b        = parity_on ? {1'b0, data_byte[6:0]} : data_byte;
    assign sum_next = sum_reg + {4'h0, b};
    assign crc_next = crc_update(crc_reg, b);

    // fold bits 7:6 of the sum into the low six bits
    assign sum6 = sum_next[5:0] + {4'h0, sum_next[7:6]};

    always_comb
    begin
        case (check_type)
            CHK_SUM12: check_value = {4'h0, sum_next};
            CHK_CRC16: check_value = crc_next;
            default:   check_value = {10'h000, sum6};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            crc_reg <= '0;
        end
        else if (step.step)
        begin
            if (step.last)
            begin
                sum_reg <= '0;
                crc_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                crc_reg <= crc_next;
            end
        end
    end

endmodule

// ===== rtl/packet_block_check.sv =====
// ----------------------------------------------------------------------------
// packet_block_check
// block check (six-bit checksum, twelve-bit sum or crc-16) over packet bytes
// ----------------------------------------------------------------------------
// Usage: packet bytes enter on the s_ stream, one byte per transfer in
// s_tdata, with s_tlast on the final byte covered by the check. Each
// byte is optionally masked to seven bits and folded into a running sum
// and crc. On the last byte one result leaves on the m_ stream: the check
// of the selected type in m_tdata, zero-extended to 16 bits; the running
// values then clear for the next packet.
// The check of a last byte is registered into the result register.
// Throughput: one byte per cycle, set by the combinational crc and sum
// update between the input and result registers; when the receiver stalls
// a held result, non-last bytes keep flowing, but a last byte waits in the
// input register until the result register frees. Reset clears both valid
// flags and the running values, sets check_type to the six-bit checksum and
// parity_on to 0. The user must write the APB registers (check_type at 0,
// parity_on at 4) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module packet_block_check
    import pbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // byte stream in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // last_byte
    // check stream out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [15:0] check_value
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [1:0]  check_type_reg;
    logic        parity_on_reg;

    pbc_step_t   step;
    logic [15:0] check_value;
    logic        out_free;
    logic        cfg_wr;

    // the result register only matters for a last byte
    assign out_free  = !out_valid_reg || m_tready;
    assign step.step = in_valid_reg && (!in_last_reg || out_free);
    assign step.last = in_last_reg;
    assign s_tready  = !in_valid_reg || step.step;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_CHECK_TYPE: prdata = {30'h0, check_type_reg};
            REG_PARITY_ON:  prdata = {31'h0, parity_on_reg};
            default:        prdata = '0;
        endcase
    end

    pbc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_data_reg),
        .check_type  (check_type_reg),
        .parity_on   (parity_on_reg),
        .check_value (check_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            check_type_reg <= CHECK_TYPE_RESET;
            parity_on_reg  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step.step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step.step && step.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_CHECK_TYPE: check_type_reg <= pwdata[1:0];
                    REG_PARITY_ON:  parity_on_reg  <= pwdata[0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step.step && step.last)
        begin
            out_data_reg <= check_value;
        end
    end

endmodule

// ===== rtl/pbc_checker.sv =====
// ----------------------------------------------------------------------------
// pbc_checker
// port-level checks on the packet block check, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbc_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,   // last_byte
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [15:0]       m_tdata,   // [15:0] check_value
    input logic              pready
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;

    // a held result stays put
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_stall |=> m_tvalid && $stable(m_tdata))

    // a new result must trace back to a transferred last byte
    `ASSERT_CLK(a_result_from_last, clk, rst_n, $rose(m_tvalid) |-> $past(in_xfer && s_tlast, 2))

    // input backpressure only comes from a stalled result
    `ASSERT_CLK(a_stall_cause, clk, rst_n, !s_tready |-> out_stall)

    // configuration never waits
    `ASSERT_NEVER(a_pready_low, clk, rst_n, !pready)

endmodule

bind packet_block_check pbc_checker u_pbc_checker (.*);

// ===== tb/tb_packet_block_check.sv =====
// ----------------------------------------------------------------------------
// tb_packet_block_check
// self-checking bench for the packet block check
// ----------------------------------------------------------------------------
// Bytes go in on the s_ stream in whole packets. Each accepted byte steps a
// local bit-serial crc and byte sum, and every last byte queues the check
// that the current register settings select. Results leaving on the m_ stream
// are compared in order. A short table of directed packets runs first, then
// random packets under every check type and parity setting, with three mixes
// of sender gaps and receiver stalls. Registers are written over APB while
// the block is idle and read back.
// ----------------------------------------------------------------------------
module tb_packet_block_check;
    import pbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_BYTES    = 61;
    localparam int DIR_ROWS       = 17;

    // type code left undefined by the block, handled as the six-bit checksum
    localparam logic [1:0] CHK_UNSET = 2'd0;

    localparam logic [ADDR_W-1:0] ADDR_CHECK_TYPE = {REG_CHECK_TYPE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_PARITY_ON  = {REG_PARITY_ON, 2'b00};

    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [1:0]  ctype;
        logic        parity;
        logic        pinned;   // check value below is given, not predicted
        logic [15:0] check;
    } byte_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;    // [7:0] data_byte
    logic              s_tlast;    // last_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;    // [15:0] check_value
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state
    logic [1:0]  cfg_type   = CHK_SUM6;
    logic        cfg_parity = 1'b0;
    logic [11:0] sum_acc    = '0;
    logic [15:0] crc_acc    = '0;

    logic [15:0] check_q [$];
    int          err_count   = 0;
    int          idle_pct    = 17;
    int          stall_pct   = 73;
    int          quiet_count = 0;

    byte_row_t dir_rows [DIR_ROWS] = '{
        // reset settings: six-bit checksum, full bytes
        '{8'h00, 1'b1, CHK_SUM6,  1'b0, 1'b1, 16'h0000},
        '{8'hFF, 1'b1, CHK_SUM6,  1'b0, 1'b1, 16'h0002},
        '{8'h00, 1'b0, CHK_SUM6,  1'b0, 1'b0, 16'h0000},
        '{8'h40, 1'b0, CHK_SUM6,  1'b0, 1'b0, 16'h0000},
        '{8'h3F, 1'b1, CHK_SUM6,  1'b0, 1'b1, 16'h0000},
        '{8'h80, 1'b0, CHK_SUM12, 1'b0, 1'b0, 16'h0000},
        '{8'hFF, 1'b1, CHK_SUM12, 1'b0, 1'b1, 16'h017F},
        '{8'h00, 1'b1, CHK_CRC16, 1'b0, 1'b1, 16'h0000},
        '{8'hFF, 1'b1, CHK_CRC16, 1'b0, 1'b1, 16'h0F78},
        '{8'h31, 1'b0, CHK_CRC16, 1'b0, 1'b0, 16'h0000},
        '{8'h32, 1'b0, CHK_CRC16, 1'b0, 1'b0, 16'h0000},
        '{8'h33, 1'b1, CHK_CRC16, 1'b0, 1'b0, 16'h0000},
        // seven-bit masking
        '{8'hFF, 1'b1, CHK_SUM12, 1'b1, 1'b1, 16'h007F},
        '{8'h80, 1'b1, CHK_SUM12, 1'b1, 1'b1, 16'h0000},
        '{8'hFF, 1'b1, CHK_CRC16, 1'b1, 1'b0, 16'h0000},
        '{8'hFF, 1'b1, CHK_SUM6,  1'b1, 1'b1, 16'h0000},
        // type zero falls back to the six-bit checksum
        '{8'hFF, 1'b1, CHK_UNSET, 1'b0, 1'b1, 16'h0002}
    };

    packet_block_check i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        err_count++;
    endtask

    // steps the running sum and crc by one byte; returns 1 with the check on a last byte
    function automatic bit fold_byte(input logic [7:0] raw, input logic last,
                                     output logic [15:0] check);
        logic [7:0]  b;
        logic [15:0] crc;
        b = cfg_parity ? (raw & 8'h7F) : raw;
        sum_acc = sum_acc + {4'h0, b};
        crc = crc_acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_REFL) : (crc >> 1);
        crc_acc = crc;
        check = '0;
        if (!last)
            return 1'b0;
        case (cfg_type)
            CHK_SUM12: check = {4'h0, sum_acc};
            CHK_CRC16: check = crc_acc;
            default:   check = {10'h000, 6'(sum_acc + {10'h000, sum_acc[7:6]})};
        endcase
        sum_acc = '0;
        crc_acc = '0;
        return 1'b1;
    endfunction

    // drains the receiver side, ready or stalled at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (check_q.size() == 0)
                report_mismatch("check_value, no result pending", 32'h0, {16'h0, m_tdata});
            else if (m_tdata !== check_q[0])
            begin
                report_mismatch("check_value", {16'h0, check_q[0]}, {16'h0, m_tdata});
                void'(check_q.pop_front());
            end
            else
                void'(check_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_count <= 0;
        else if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    task automatic send_byte(input logic [7:0] d, input logic last, input logic pinned,
                             input logic [15:0] pinned_check);
        logic [15:0] check;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (fold_byte(d, last, check))
            check_q.push_back(pinned ? pinned_check : check);
    endtask

    task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // registers change only once all checks are out and the pipeline is empty
    task automatic load_config(input logic [1:0] kind, input logic parity);
        logic [31:0] rd;
        s_tvalid <= 1'b0;
        while (check_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_access(1'b1, ADDR_CHECK_TYPE, {30'd0, kind}, rd);
        cfg_type = kind;
        apb_access(1'b1, ADDR_PARITY_ON, {31'd0, parity}, rd);
        cfg_parity = parity;
        apb_access(1'b0, ADDR_CHECK_TYPE, 32'd0, rd);
        if (rd !== {30'd0, kind})
            report_mismatch("check_type readback", {30'd0, kind}, rd);
        apb_access(1'b0, ADDR_PARITY_ON, 32'd0, rd);
        if (rd !== {31'd0, parity})
            report_mismatch("parity_on readback", {31'd0, parity}, rd);
    endtask

    task automatic send_packet(output int n);
        int         style;
        logic [7:0] b;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        style = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0:       b = 8'hFF;
                1:       b = $urandom_range(0, 1) ? 8'h00 : 8'h80;
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == n - 1, 1'b0, 16'h0000);
        end
    endtask

    initial
    begin
        logic [1:0] phase_types [4];
        int         sent;
        int         n;
        phase_types = '{CHK_UNSET, CHK_SUM6, CHK_SUM12, CHK_CRC16};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // the first packets run on the reset settings, no register written yet
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].ctype != cfg_type || dir_rows[r].parity != cfg_parity)
                load_config(dir_rows[r].ctype, dir_rows[r].parity);
            send_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].pinned,
                      dir_rows[r].check);
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                load_config(phase_types[k], 1'((k + mode) % 2));
                idle_pct  = (mode == 0) ? 17 : (mode == 1) ? 73 : 0;
                stall_pct = (mode == 0) ? 73 : (mode == 1) ? 17 : 0;
                sent = 0;
                while (sent < PHASE_BYTES)
                begin
                    send_packet(n);
                    sent += n;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (check_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== packet_block_check.f =====
+incdir+rtl
rtl/pbc_pkg.sv
rtl/pbc_core.sv
rtl/packet_block_check.sv
rtl/pbc_checker.sv
tb/tb_packet_block_check.sv
